// ----- hdl/tfl_pkg.sv -----
// Shared types, constants and a helper function of the translation buffer.
`timescale 1ns / 1ps
`default_nettype none

package tfl_pkg;

    localparam int TLB_DEPTH = 16;
    localparam int POS_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TLB_DEPTH + 1);

    localparam int OP_W      = 2;
    localparam int PROC_W    = 16;
    localparam int PAGE_W    = 20;
    localparam int FRAME_W   = 20;
    localparam int ENTRIES_W = 5;
    localparam int CFG_W     = 5;
    localparam int LIM_W     = (CNT_W > ENTRIES_W) ? CNT_W : ENTRIES_W;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    localparam logic CFG_ENTRIES = 1'b0;
    localparam logic CFG_POLICY  = 1'b1;

    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 5'd16;
    localparam logic                 POLICY_FIFO   = 1'b0;

    typedef struct packed {
        logic [PROC_W-1:0]  proc_id;
        logic [PAGE_W-1:0]  page_num;
        logic [FRAME_W-1:0] frame;
        logic [POS_W-1:0]   rr;
    } data_t;

    typedef struct packed {
        logic  valid;
        data_t data;
    } entry_t;

    // Broadcast command from the controller to every cell of the chain.
    typedef struct packed {
        logic             remove;
        logic [POS_W-1:0] rm_pos;
        logic [POS_W-1:0] rm_rr;
        logic             touch;
        logic [POS_W-1:0] touch_pos;
        logic [POS_W-1:0] touch_rr;
        logic [POS_W-1:0] top_rr;
        logic             append;
        logic [POS_W-1:0] app_pos;
        data_t            new_data;
    } cmd_t;

    // Position of the lowest set bit; zero when no bit is set.
    function automatic logic [POS_W-1:0] first_set(input logic [TLB_DEPTH-1:0] v);
        logic [POS_W-1:0] r;
        r = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = POS_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tfl_cell.sv -----
// One slot of the translation buffer chain; it shifts down to close holes.
`timescale 1ns / 1ps
`default_nettype none

module tfl_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [tfl_pkg::POS_W-1:0] pos,
    input  wire tfl_pkg::cmd_t           cmd,
    input  wire tfl_pkg::entry_t         up,
    output tfl_pkg::entry_t              cur
);

    logic           valid_reg;
    logic           valid_next;
    tfl_pkg::data_t data_reg;
    tfl_pkg::data_t data_next;

    assign cur.valid = valid_reg;
    assign cur.data  = data_reg;

    always_comb
    begin
        tfl_pkg::entry_t src;
        src        = cur;
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (cmd.remove)
        begin
            // Slots at and above the removed one take the word from above.
            if (pos >= cmd.rm_pos)
            begin
                src = up;
            end
            valid_next = src.valid;
            data_next  = src.data;
            if (src.valid && (src.data.rr > cmd.rm_rr))
            begin
                data_next.rr = src.data.rr - 1'b1;
            end
        end
        else if (cmd.touch)
        begin
            if (pos == cmd.touch_pos)
            begin
                data_next.rr = cmd.top_rr;
            end
            else if (valid_reg && (data_reg.rr > cmd.touch_rr))
            begin
                data_next.rr = data_reg.rr - 1'b1;
            end
        end
        else if (cmd.append && (pos == cmd.app_pos))
        begin
            valid_next = 1'b1;
            data_next  = cmd.new_data;
        end
        else
        begin
            // No command for this slot: it keeps its word.
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ----- hdl/tlb_fifo_lru_with_pid_flush.sv -----
// Top level: controller and chain of slots of the process-tagged translation buffer.
// Lookup, flush with no match, insert without eviction and the unused op: the result
// is registered once the output is free, and the next word is taken only after it.
// Insert that evicts: the victim is removed first, then the word is appended. Flush:
// one matching slot is removed per cycle, then the result; the next word waits for it.
// Reset: all slots invalid, entries register 16, FIFO replacement, output empty.
`timescale 1ns / 1ps
`default_nettype none

module tlb_fifo_lru_with_pid_flush (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tfl_pkg::OP_W-1:0]      op,
    input  wire logic [tfl_pkg::PROC_W-1:0]    proc_id,
    input  wire logic [tfl_pkg::PAGE_W-1:0]    page_num,
    input  wire logic [tfl_pkg::FRAME_W-1:0]   frame_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               hit,
    output logic [tfl_pkg::FRAME_W-1:0]        frame_out,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [tfl_pkg::CFG_W-1:0]     cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                            state_reg;
    logic                            state_next;
    logic                            evicted_reg;
    logic                            evicted_next;
    logic [tfl_pkg::CNT_W-1:0]       count_reg;
    logic [tfl_pkg::CNT_W-1:0]       count_next;
    logic [tfl_pkg::ENTRIES_W-1:0]   entries_reg;
    logic                            policy_reg;
    logic [tfl_pkg::OP_W-1:0]        op_reg;
    logic [tfl_pkg::PROC_W-1:0]      pid_reg;
    logic [tfl_pkg::PAGE_W-1:0]      page_reg;
    logic [tfl_pkg::FRAME_W-1:0]     frame_reg;
    logic                            out_valid_reg;
    logic                            hit_reg;
    logic [tfl_pkg::FRAME_W-1:0]     frame_out_reg;

    tfl_pkg::entry_t                 cell_q  [tfl_pkg::TLB_DEPTH];
    tfl_pkg::entry_t                 cell_up [tfl_pkg::TLB_DEPTH];
    tfl_pkg::cmd_t                   cmd;

    logic [tfl_pkg::TLB_DEPTH-1:0]   look_match;
    logic [tfl_pkg::TLB_DEPTH-1:0]   flush_match;
    logic [tfl_pkg::TLB_DEPTH-1:0]   lru_zero;
    logic [tfl_pkg::POS_W-1:0]       hit_pos;
    logic [tfl_pkg::POS_W-1:0]       flush_pos;
    logic [tfl_pkg::POS_W-1:0]       lru_pos;
    logic [tfl_pkg::LIM_W-1:0]       entries_ext;
    logic [tfl_pkg::LIM_W-1:0]       limit;
    logic                            out_free;
    logic                            done;
    logic                            res_hit;
    logic [tfl_pkg::FRAME_W-1:0]     res_frame;

    genvar gi;
    generate
        for (gi = 0; gi < tfl_pkg::TLB_DEPTH; gi++)
        begin : g_cell
            if (gi == tfl_pkg::TLB_DEPTH - 1)
            begin : g_top
                assign cell_up[gi] = '0;
            end
            else
            begin : g_mid
                assign cell_up[gi] = cell_q[gi+1];
            end

            assign look_match[gi]  = cell_q[gi].valid
                                     && (cell_q[gi].data.proc_id == pid_reg)
                                     && (cell_q[gi].data.page_num == page_reg);
            assign flush_match[gi] = cell_q[gi].valid && (cell_q[gi].data.proc_id == pid_reg);
            assign lru_zero[gi]    = cell_q[gi].valid && (cell_q[gi].data.rr == '0);

            tfl_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .pos   (tfl_pkg::POS_W'(gi)),
                .cmd   (cmd),
                .up    (cell_up[gi]),
                .cur   (cell_q[gi])
            );
        end
    endgenerate

    // Earliest inserted match sits at the lowest position of the chain.
    assign hit_pos   = tfl_pkg::first_set(look_match);
    assign flush_pos = tfl_pkg::first_set(flush_match);
    assign lru_pos   = tfl_pkg::first_set(lru_zero);

    assign entries_ext = tfl_pkg::LIM_W'(entries_reg);
    assign limit = (entries_ext > tfl_pkg::LIM_W'(tfl_pkg::TLB_DEPTH))
                   ? tfl_pkg::LIM_W'(tfl_pkg::TLB_DEPTH) : entries_ext;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign frame_out = frame_out_reg;

    always_comb
    begin
        logic [tfl_pkg::POS_W-1:0] victim;
        victim       = '0;
        cmd          = '0;
        state_next   = state_reg;
        evicted_next = evicted_reg;
        count_next   = count_reg;
        done         = 1'b0;
        res_hit      = 1'b0;
        res_frame    = '0;

        if (state_reg == ST_IDLE)
        begin
            if (in_valid)
            begin
                state_next = ST_EXEC;
            end
        end
        else
        begin
            unique case (op_reg)
                tfl_pkg::OP_LOOKUP:
                begin
                    if (out_free)
                    begin
                        done = 1'b1;
                        if ((limit != '0) && (|look_match))
                        begin
                            res_hit       = 1'b1;
                            res_frame     = cell_q[hit_pos].data.frame;
                            cmd.touch     = 1'b1;
                            cmd.touch_pos = hit_pos;
                            cmd.touch_rr  = cell_q[hit_pos].data.rr;
                            cmd.top_rr    = tfl_pkg::POS_W'(count_reg - 1'b1);
                        end
                    end
                end
                tfl_pkg::OP_INSERT:
                begin
                    if (limit == '0)
                    begin
                        done = out_free;
                    end
                    else if (!evicted_reg && (tfl_pkg::LIM_W'(count_reg) >= limit))
                    begin
                        victim       = policy_reg ? lru_pos : '0;
                        cmd.remove   = 1'b1;
                        cmd.rm_pos   = victim;
                        cmd.rm_rr    = cell_q[victim].data.rr;
                        count_next   = count_reg - 1'b1;
                        evicted_next = 1'b1;
                    end
                    else if (out_free)
                    begin
                        cmd.append            = 1'b1;
                        cmd.app_pos           = tfl_pkg::POS_W'(count_reg);
                        cmd.new_data.proc_id  = pid_reg;
                        cmd.new_data.page_num = page_reg;
                        cmd.new_data.frame    = frame_reg;
                        cmd.new_data.rr       = tfl_pkg::POS_W'(count_reg);
                        count_next            = count_reg + 1'b1;
                        done                  = 1'b1;
                    end
                end
                tfl_pkg::OP_FLUSH:
                begin
                    if (|flush_match)
                    begin
                        cmd.remove = 1'b1;
                        cmd.rm_pos = flush_pos;
                        cmd.rm_rr  = cell_q[flush_pos].data.rr;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        done = out_free;
                    end
                end
                default:
                begin
                    done = out_free;
                end
            endcase
            if (done)
            begin
                state_next   = ST_IDLE;
                evicted_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            evicted_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            entries_reg   <= tfl_pkg::ENTRIES_RESET;
            policy_reg    <= tfl_pkg::POLICY_FIFO;
        end
        else
        begin
            state_reg   <= state_next;
            evicted_reg <= evicted_next;
            count_reg   <= count_next;
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tfl_pkg::CFG_ENTRIES: entries_reg <= cfg_data[tfl_pkg::ENTRIES_W-1:0];
                    tfl_pkg::CFG_POLICY:  policy_reg  <= cfg_data[0];
                    default:              policy_reg  <= policy_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            op_reg    <= op;
            pid_reg   <= proc_id;
            page_reg  <= page_num;
            frame_reg <= frame_in;
        end
        if (done)
        begin
            hit_reg       <= res_hit;
            frame_out_reg <= res_frame;
        end
    end

endmodule

`default_nettype wire

// ----- verif/tlb_translation_check.sv -----
// Shadow translation buffer that predicts every result word and compares it with the block.
`timescale 1ns / 1ps

module tlb_translation_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [tfl_pkg::OP_W-1:0]      op,
    input  wire logic [tfl_pkg::PROC_W-1:0]    proc_id,
    input  wire logic [tfl_pkg::PAGE_W-1:0]    page_num,
    input  wire logic [tfl_pkg::FRAME_W-1:0]   frame_in,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          hit,
    input  wire logic [tfl_pkg::FRAME_W-1:0]   frame_out,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [tfl_pkg::CFG_W-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 answers_due,
    output int                                 answers_seen,
    output int                                 hits_seen,
    output int                                 evictions,
    output int                                 flushed_slots
);

    typedef struct packed {
        logic                        hit;
        logic [tfl_pkg::FRAME_W-1:0] frame;
    } answer_t;

    answer_t expected_answers[$];

    logic                        slot_valid [tfl_pkg::TLB_DEPTH];
    logic [tfl_pkg::PROC_W-1:0]  slot_proc  [tfl_pkg::TLB_DEPTH];
    logic [tfl_pkg::PAGE_W-1:0]  slot_page  [tfl_pkg::TLB_DEPTH];
    logic [tfl_pkg::FRAME_W-1:0] slot_frame [tfl_pkg::TLB_DEPTH];
    // Both orders count from zero among the valid slots with no gaps.
    int                          slot_age   [tfl_pkg::TLB_DEPTH];
    int                          slot_use   [tfl_pkg::TLB_DEPTH];

    logic [tfl_pkg::ENTRIES_W-1:0] usable_entries;
    logic                          lru_mode;

    function automatic int held_slots();
        int n;
        n = 0;
        for (int i = 0; i < tfl_pkg::TLB_DEPTH; i++)
        begin
            if (slot_valid[i])
            begin
                n++;
            end
        end
        return n;
    endfunction

    task automatic drop_slot(input int s);
        int a;
        int u;
        a = slot_age[s];
        u = slot_use[s];
        slot_valid[s] = 1'b0;
        for (int i = 0; i < tfl_pkg::TLB_DEPTH; i++)
        begin
            if (slot_valid[i])
            begin
                if (slot_age[i] > a)
                begin
                    slot_age[i]--;
                end
                if (slot_use[i] > u)
                begin
                    slot_use[i]--;
                end
            end
        end
    endtask

    task automatic touch_slot(input int s);
        int u;
        int top;
        u = slot_use[s];
        top = 0;
        for (int i = 0; i < tfl_pkg::TLB_DEPTH; i++)
        begin
            if (slot_valid[i])
            begin
                top++;
                if (slot_use[i] > u)
                begin
                    slot_use[i]--;
                end
            end
        end
        slot_use[s] = top - 1;
    endtask

    task automatic tlb_predict(
        input  logic [tfl_pkg::OP_W-1:0]    o,
        input  logic [tfl_pkg::PROC_W-1:0]  pid,
        input  logic [tfl_pkg::PAGE_W-1:0]  page,
        input  logic [tfl_pkg::FRAME_W-1:0] frame,
        output answer_t                     ans
    );
        int lim;
        int best;
        int n;
        int r;
        ans = '0;
        lim = (usable_entries > tfl_pkg::TLB_DEPTH) ? tfl_pkg::TLB_DEPTH : int'(usable_entries);
        case (o)
            tfl_pkg::OP_LOOKUP:
            begin
                if (lim != 0)
                begin
                    // Among duplicates the earliest inserted slot answers.
                    best = -1;
                    for (int i = 0; i < tfl_pkg::TLB_DEPTH; i++)
                    begin
                        if (slot_valid[i] && slot_proc[i] == pid && slot_page[i] == page &&
                            (best < 0 || slot_age[i] < slot_age[best]))
                        begin
                            best = i;
                        end
                    end
                    if (best >= 0)
                    begin
                        ans.hit   = 1'b1;
                        ans.frame = slot_frame[best];
                        touch_slot(best);
                    end
                end
            end
            tfl_pkg::OP_INSERT:
            begin
                if (lim != 0)
                begin
                    if (held_slots() >= lim)
                    begin
                        for (int i = 0; i < tfl_pkg::TLB_DEPTH; i++)
                        begin
                            r = lru_mode ? slot_use[i] : slot_age[i];
                            if (slot_valid[i] && r == 0)
                            begin
                                drop_slot(i);
                                evictions++;
                                break;
                            end
                        end
                    end
                    n = held_slots();
                    for (int i = 0; i < tfl_pkg::TLB_DEPTH; i++)
                    begin
                        if (!slot_valid[i])
                        begin
                            slot_valid[i] = 1'b1;
                            slot_proc[i]  = pid;
                            slot_page[i]  = page;
                            slot_frame[i] = frame;
                            slot_age[i]   = n;
                            slot_use[i]   = n;
                            break;
                        end
                    end
                end
            end
            tfl_pkg::OP_FLUSH:
            begin
                for (int i = 0; i < tfl_pkg::TLB_DEPTH; i++)
                begin
                    if (slot_valid[i] && slot_proc[i] == pid)
                    begin
                        drop_slot(i);
                        flushed_slots++;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < tfl_pkg::TLB_DEPTH; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_proc[i]  = '0;
                slot_page[i]  = '0;
                slot_frame[i] = '0;
                slot_age[i]   = 0;
                slot_use[i]   = 0;
            end
            usable_entries = tfl_pkg::ENTRIES_RESET;
            lru_mode       = tfl_pkg::POLICY_FIFO;
            expected_answers.delete();
            mismatches    = 0;
            answers_due   = 0;
            answers_seen  = 0;
            hits_seen     = 0;
            evictions     = 0;
            flushed_slots = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tfl_pkg::CFG_ENTRIES)
                begin
                    usable_entries = cfg_data[tfl_pkg::ENTRIES_W-1:0];
                end
                else
                begin
                    lru_mode = cfg_data[0];
                end
            end
            if (in_valid && !in_stall)
            begin
                tlb_predict(op, proc_id, page_num, frame_in, want);
                expected_answers.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                answers_seen++;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    $error("result word with no prediction waiting: hit %0d frame_out 'h%05h",
                           hit, frame_out);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (want.hit)
                    begin
                        hits_seen++;
                    end
                    if (hit !== want.hit)
                    begin
                        mismatches++;
                        $error("hit: expected %0d, actual %0d", want.hit, hit);
                    end
                    if (frame_out !== want.frame)
                    begin
                        mismatches++;
                        $error("frame_out: expected 'h%05h, actual 'h%05h", want.frame, frame_out);
                    end
                end
            end
            answers_due = expected_answers.size();
        end
    end

endmodule

// ----- verif/tb_tlb_fifo_lru_with_pid_flush.sv -----
// Testbench top: drives lookups, inserts and flushes through the handshake and gives the verdict.
`timescale 1ns / 1ps

module tb_tlb_fifo_lru_with_pid_flush;

    localparam logic [tfl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STUCK_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES = 12;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    wire logic                   in_stall;
    logic [tfl_pkg::OP_W-1:0]    op;
    logic [tfl_pkg::PROC_W-1:0]  proc_id;
    logic [tfl_pkg::PAGE_W-1:0]  page_num;
    logic [tfl_pkg::FRAME_W-1:0] frame_in;
    wire logic                   out_valid;
    logic                        out_stall;
    wire logic                   hit;
    wire logic [tfl_pkg::FRAME_W-1:0] frame_out;
    logic                        cfg_we;
    logic                        cfg_index;
    logic [tfl_pkg::CFG_W-1:0]   cfg_data;

    int mismatches;
    int answers_due;
    int answers_seen;
    int hits_seen;
    int evictions;
    int flushed_slots;

    logic tx_idle;
    logic rx_idle;
    int   rx_wait;
    int   stuck_cycles;
    int   settings_used;

    logic [tfl_pkg::PROC_W-1:0] pid_pool    [4];
    logic [tfl_pkg::PAGE_W-1:0] page_pool   [8];
    logic [tfl_pkg::PROC_W-1:0] recent_pid  [16];
    logic [tfl_pkg::PAGE_W-1:0] recent_page [16];
    int recent_count;
    int recent_next;

    tlb_fifo_lru_with_pid_flush u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .proc_id   (proc_id),
        .page_num  (page_num),
        .frame_in  (frame_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .frame_out (frame_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tlb_translation_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .proc_id       (proc_id),
        .page_num      (page_num),
        .frame_in      (frame_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_out     (frame_out),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .answers_due   (answers_due),
        .answers_seen  (answers_seen),
        .hits_seen     (hits_seen),
        .evictions     (evictions),
        .flushed_slots (flushed_slots)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // When rx_idle is set, the receiver holds off for a fresh random count after every word it takes.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
        end
    end

    always @(negedge clk)
    begin
        if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(
        input logic [tfl_pkg::OP_W-1:0]    o,
        input logic [tfl_pkg::PROC_W-1:0]  p,
        input logic [tfl_pkg::PAGE_W-1:0]  g,
        input logic [tfl_pkg::FRAME_W-1:0] f
    );
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        proc_id  <= p;
        page_num <= g;
        frame_in <= f;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
            begin
                break;
            end
        end
        @(negedge clk);
        if (o == tfl_pkg::OP_INSERT)
        begin
            recent_pid[recent_next]  = p;
            recent_page[recent_next] = g;
            recent_next = (recent_next + 1) % 16;
            if (recent_count < 16)
            begin
                recent_count++;
            end
        end
    endtask

    task automatic wait_answers();
        while (answers_due != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Registers change only once the block has gone quiet.
    task automatic set_config(input int entries, input logic policy);
        logic [tfl_pkg::CFG_W-2:0] junk;
        junk = (tfl_pkg::CFG_W-1)'($urandom);
        in_valid <= 1'b0;
        wait_answers();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= tfl_pkg::CFG_ENTRIES;
        cfg_data  <= tfl_pkg::CFG_W'(entries);
        @(negedge clk);
        cfg_index <= tfl_pkg::CFG_POLICY;
        cfg_data  <= {junk, policy};
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_word();
        int r;
        int k;
        logic [tfl_pkg::OP_W-1:0]   o;
        logic [tfl_pkg::PROC_W-1:0] p;
        logic [tfl_pkg::PAGE_W-1:0] g;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            o = tfl_pkg::OP_LOOKUP;
        end
        else if (r < 82)
        begin
            o = tfl_pkg::OP_INSERT;
        end
        else if (r < 96)
        begin
            o = tfl_pkg::OP_FLUSH;
        end
        else
        begin
            o = OP_UNUSED;
        end
        p = ($urandom_range(0, 9) < 7) ? pid_pool[$urandom_range(0, 3)]
                                       : tfl_pkg::PROC_W'($urandom);
        g = ($urandom_range(0, 9) < 7) ? page_pool[$urandom_range(0, 7)]
                                       : tfl_pkg::PAGE_W'($urandom);
        // Lean lookups and flushes toward what was recently inserted so they find matches.
        if (recent_count > 0 && (o == tfl_pkg::OP_LOOKUP || o == tfl_pkg::OP_FLUSH)
            && $urandom_range(0, 1))
        begin
            k = $urandom_range(0, recent_count - 1);
            p = recent_pid[k];
            if (o == tfl_pkg::OP_LOOKUP)
            begin
                g = recent_page[k];
            end
        end
        send_word(o, p, g, tfl_pkg::FRAME_W'($urandom));
    endtask

    initial
    begin
        int ph_entries [PHASES];
        int ph_policy  [PHASES];
        int e;
        int pol;
        int items;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = tfl_pkg::OP_LOOKUP;
        proc_id      = '0;
        page_num     = '0;
        frame_in     = '0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = tfl_pkg::CFG_ENTRIES;
        cfg_data     = '0;
        rx_wait      = 0;
        stuck_cycles = 0;
        recent_count = 0;
        recent_next  = 0;
        settings_used = 1;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;

        // A negative value draws the setting at random.
        ph_entries = '{16, 16, 2, 1, 31, 0, 8, 3, -1, -1, -1, 16};
        ph_policy  = '{0, 1, 1, 0, 1, 0, 0, 1, -1, -1, -1, 1};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset settings.
        send_word(tfl_pkg::OP_LOOKUP, 16'h0000, 20'h00000, 20'h00000);
        send_word(tfl_pkg::OP_INSERT, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
        send_word(tfl_pkg::OP_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
        send_word(tfl_pkg::OP_INSERT, 16'h0000, 20'h00000, 20'h00000);
        send_word(tfl_pkg::OP_LOOKUP, 16'h0000, 20'h00000, 20'h12345);
        send_word(tfl_pkg::OP_INSERT, 16'h0005, 20'h00007, 20'hAAAAA);
        send_word(tfl_pkg::OP_INSERT, 16'h0005, 20'h00007, 20'h55555);
        send_word(tfl_pkg::OP_LOOKUP, 16'h0005, 20'h00007, 20'h00000);
        send_word(tfl_pkg::OP_LOOKUP, 16'h0005, 20'h00007, 20'h00000);
        send_word(OP_UNUSED,          16'hFFFF, 20'hFFFFF, 20'hFFFFF);
        send_word(tfl_pkg::OP_FLUSH,  16'h0005, 20'h00000, 20'h00000);
        send_word(tfl_pkg::OP_LOOKUP, 16'h0005, 20'h00007, 20'h00000);
        send_word(tfl_pkg::OP_FLUSH,  16'h1234, 20'hFFFFF, 20'hFFFFF);
        // Disabled buffer: lookups miss, inserts vanish, flushes still drop.
        set_config(0, 1'b1);
        send_word(tfl_pkg::OP_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000);
        send_word(tfl_pkg::OP_INSERT, 16'h0009, 20'h00009, 20'h00009);
        send_word(tfl_pkg::OP_FLUSH,  16'hFFFF, 20'h00000, 20'h00000);
        set_config(16, 1'b0);
        send_word(tfl_pkg::OP_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000);
        send_word(tfl_pkg::OP_LOOKUP, 16'h0009, 20'h00009, 20'h00000);
        send_word(tfl_pkg::OP_LOOKUP, 16'h0000, 20'h00000, 20'h00000);
        // Two usable slots with one already held: the second insert here pushes out the oldest.
        set_config(2, 1'b0);
        send_word(tfl_pkg::OP_INSERT, 16'h0001, 20'h00001, 20'h00011);
        send_word(tfl_pkg::OP_INSERT, 16'h0002, 20'h00002, 20'h00022);
        send_word(tfl_pkg::OP_LOOKUP, 16'h0000, 20'h00000, 20'h00000);
        send_word(tfl_pkg::OP_LOOKUP, 16'h0001, 20'h00001, 20'h00000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            e   = (ph_entries[ph] < 0) ? $urandom_range(0, 31) : ph_entries[ph];
            pol = (ph_policy[ph] < 0) ? $urandom_range(0, 1) : ph_policy[ph];
            for (int i = 0; i < 4; i++)
            begin
                pid_pool[i] = tfl_pkg::PROC_W'($urandom);
            end
            for (int i = 0; i < 8; i++)
            begin
                page_pool[i] = tfl_pkg::PAGE_W'($urandom);
            end
            recent_count = 0;
            set_config(e, pol[0]);
            if (ph % 4 == 1)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            items = (e == 0) ? 60 : 170;
            for (int n = 0; n < items; n++)
            begin
                random_word();
                if ($urandom_range(0, 49) == 0)
                begin
                    in_valid <= 1'b0;
                    wait_answers();
                end
            end
        end

        in_valid <= 1'b0;
        wait_answers();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Checked %0d result words (%0d hits), %0d evictions, %0d flushed slots",
                 answers_seen, hits_seen, evictions, flushed_slots);
        $display("across %0d register settings, FIFO and LRU, with and without idling.",
                 settings_used);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
